// ----- hdl/sbi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbi_pkg
// Shared types and constants for the sorted breakpoint table.
// ----------------------------------------------------------------------------
package sbi_pkg;

    // Default table depth
    localparam int SBI_DEPTH_DEFAULT = 64;

    // Field widths
    localparam int SBI_TIME_W  = 32;
    localparam int SBI_VALUE_W = 32;
    localparam int SBI_INDEX_W = 6;
    localparam int SBI_POS_W   = 6;
    localparam int SBI_COUNT_W = 7;
    localparam int SBI_ENTRY_W = SBI_TIME_W + SBI_VALUE_W;

    // Stream word widths (padded to whole bytes)
    localparam int SBI_S_DATA_W = 72;
    localparam int SBI_M_DATA_W = 80;

    // Item modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REPLACED = 3'd1,
        ST_NEGATIVE = 3'd2,
        ST_FULL     = 3'd3,
        ST_READ     = 3'd4
    } status_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_PLACE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESULT
    } state_t;

    // Read address select
    typedef enum logic [1:0] {
        RA_IDX,
        RA_SCAN,
        RA_MV
    } rd_sel_t;

    // Write address / data select
    typedef enum logic [1:0] {
        WS_REPL,
        WS_SHIFT,
        WS_INS
    } wr_sel_t;

    // Result position select
    typedef enum logic [1:0] {
        POS_ZERO,
        POS_IDX,
        POS_SCAN_M1,
        POS_SCAN
    } pos_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     capture;
        logic     ram_rd;
        rd_sel_t  rd_sel;
        logic     ram_wr;
        wr_sel_t  wr_sel;
        logic     scan_load;
        logic     scan_dec;
        logic     mv_load;
        logic     mv_dec;
        logic     cnt_inc;
        logic     res_load;
        status_t  res_status;
        pos_sel_t res_pos;
        logic     res_use_rd;
        logic     out_load;
    } sbi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic mode;
        logic negative;
        logic idx_ok;
        logic scan_zero;
        logic cmp_eq;
        logic cmp_lt;
        logic full;
        logic mv_at_slot;
        logic out_free;
    } sbi_stat_t;

endpackage : sbi_pkg
`default_nettype wire

// ----- hdl/sbi_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbi_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : sbi_ram
`default_nettype wire

// ----- hdl/sbi_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbi_ctrl
// Sequencer for reads, search, replace, shift-up and insert of the table.
// ----------------------------------------------------------------------------
module sbi_ctrl
    import sbi_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire sbi_stat_t stat,
    output sbi_cmd_t       cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = RA_IDX;
        cmd.wr_sel     = WS_REPL;
        cmd.res_status = ST_READ;
        cmd.res_pos    = POS_ZERO;
        s_tready       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE: begin
                if (stat.mode == MODE_READ) begin
                    if (stat.idx_ok) begin
                        cmd.ram_rd = 1'b1;
                        cmd.rd_sel = RA_IDX;
                        state_next = S_RD_WAIT;
                    end else begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_READ;
                        cmd.res_pos    = POS_IDX;
                        state_next     = S_RESULT;
                    end
                end else if (stat.negative) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NEGATIVE;
                    state_next     = S_RESULT;
                end else begin
                    cmd.scan_load = 1'b1;
                    state_next    = S_SRCH_RD;
                end
            end

            S_RD_WAIT: begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_READ;
                cmd.res_pos    = POS_IDX;
                cmd.res_use_rd = 1'b1;
                state_next     = S_RESULT;
            end

            // Walk down from the top entry while stored times are larger
            S_SRCH_RD: begin
                if (stat.scan_zero) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.ram_rd = 1'b1;
                    cmd.rd_sel = RA_SCAN;
                    state_next = S_SRCH_CHK;
                end
            end

            S_SRCH_CHK: begin
                if (stat.cmp_eq) begin
                    cmd.ram_wr     = 1'b1;
                    cmd.wr_sel     = WS_REPL;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_REPLACED;
                    cmd.res_pos    = POS_SCAN_M1;
                    state_next     = S_RESULT;
                end else if (stat.cmp_lt) begin
                    state_next = S_PLACE;
                end else begin
                    cmd.scan_dec = 1'b1;
                    state_next   = S_SRCH_RD;
                end
            end

            S_PLACE: begin
                if (stat.full) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_FULL;
                    state_next     = S_RESULT;
                end else begin
                    cmd.mv_load = 1'b1;
                    state_next  = S_SHIFT_RD;
                end
            end

            // Move entries above the slot up by one, then write the new pair
            S_SHIFT_RD: begin
                if (stat.mv_at_slot) begin
                    cmd.ram_wr     = 1'b1;
                    cmd.wr_sel     = WS_INS;
                    cmd.cnt_inc    = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_INSERTED;
                    cmd.res_pos    = POS_SCAN;
                    state_next     = S_RESULT;
                end else begin
                    cmd.ram_rd = 1'b1;
                    cmd.rd_sel = RA_MV;
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR: begin
                cmd.ram_wr = 1'b1;
                cmd.wr_sel = WS_SHIFT;
                cmd.mv_dec = 1'b1;
                state_next = S_SHIFT_RD;
            end

            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule : sbi_ctrl
`default_nettype wire

// ----- hdl/sbi_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbi_dpath
// Item registers, entry count, scan pointers, table RAM and result register.
// ----------------------------------------------------------------------------
module sbi_dpath
    import sbi_pkg::*;
#(
    parameter int DEPTH = SBI_DEPTH_DEFAULT
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire sbi_cmd_t                cmd,
    output sbi_stat_t                    stat,
    input  wire logic [SBI_S_DATA_W-1:0] s_tdata,
    input  wire logic                    s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic      [SBI_M_DATA_W-1:0] m_tdata,
    output logic      [2:0]              m_tuser
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Captured item
    logic                          mode_reg;
    logic signed [SBI_TIME_W-1:0]  time_reg;
    logic        [SBI_VALUE_W-1:0] value_reg;
    logic        [SBI_INDEX_W-1:0] idx_reg;

    // Control counters
    logic [CW-1:0] count_reg, scan_reg, mv_reg;
    logic [CW-1:0] scan_m1, mv_m1;

    // Result and output registers
    status_t                       res_status_reg;
    logic        [SBI_POS_W-1:0]   res_pos_reg;
    logic        [SBI_TIME_W-1:0]  res_time_reg;
    logic        [SBI_VALUE_W-1:0] res_value_reg;
    logic                          m_tvalid_reg;
    status_t                       m_status_reg;
    logic        [SBI_POS_W-1:0]   m_pos_reg;
    logic        [SBI_COUNT_W-1:0] m_count_reg;
    logic        [SBI_TIME_W-1:0]  m_time_reg;
    logic        [SBI_VALUE_W-1:0] m_value_reg;

    // RAM ports
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [SBI_ENTRY_W-1:0] ram_wr_data;
    logic [AW-1:0]          ram_rd_addr;
    logic [SBI_ENTRY_W-1:0] ram_rd_data;
    logic [SBI_TIME_W-1:0]  rd_time;

    // Widened views for compare and masking
    logic [CW+SBI_INDEX_W:0]   idx_ext;
    logic [CW+SBI_INDEX_W:0]   count_ext;
    logic [CW+SBI_POS_W-1:0]   scan_pos_ext;
    logic [CW+SBI_POS_W-1:0]   scan_m1_pos_ext;
    logic [CW+SBI_COUNT_W-1:0] count_out_ext;
    logic [SBI_POS_W-1:0]      pos_sel;

    assign scan_m1         = scan_reg - CW'(1);
    assign mv_m1           = mv_reg - CW'(1);
    assign idx_ext         = {{(CW + 1){1'b0}}, idx_reg};
    assign count_ext       = {{(SBI_INDEX_W + 1){1'b0}}, count_reg};
    assign scan_pos_ext    = {{SBI_POS_W{1'b0}}, scan_reg};
    assign scan_m1_pos_ext = {{SBI_POS_W{1'b0}}, scan_m1};
    assign count_out_ext   = {{SBI_COUNT_W{1'b0}}, count_reg};
    assign rd_time         = ram_rd_data[SBI_TIME_W-1:0];

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= s_tuser;
            time_reg  <= s_tdata[31:0];
            value_reg <= s_tdata[63:32];
            idx_reg   <= s_tdata[69:64];
        end
    end

    // Entry count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.cnt_inc) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    // Search and shift pointers
    always_ff @(posedge aclk) begin
        if (cmd.scan_load) begin
            scan_reg <= count_reg;
        end else if (cmd.scan_dec) begin
            scan_reg <= scan_m1;
        end
        if (cmd.mv_load) begin
            mv_reg <= count_reg;
        end else if (cmd.mv_dec) begin
            mv_reg <= mv_m1;
        end
    end

    // RAM address and data selection
    always_comb begin
        case (cmd.rd_sel)
            RA_SCAN: ram_rd_addr = scan_m1[AW-1:0];
            RA_MV:   ram_rd_addr = mv_m1[AW-1:0];
            default: ram_rd_addr = idx_ext[AW-1:0];
        endcase
        case (cmd.wr_sel)
            WS_SHIFT: begin
                ram_wr_addr = mv_reg[AW-1:0];
                ram_wr_data = ram_rd_data;
            end
            WS_INS: begin
                ram_wr_addr = scan_reg[AW-1:0];
                ram_wr_data = {value_reg, time_reg};
            end
            default: begin
                ram_wr_addr = scan_m1[AW-1:0];
                ram_wr_data = {value_reg, time_reg};
            end
        endcase
    end

    assign ram_wr_en = cmd.ram_wr;

    sbi_ram #(
        .WIDTH (SBI_ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.ram_rd),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Result position
    always_comb begin
        case (cmd.res_pos)
            POS_IDX:     pos_sel = idx_reg;
            POS_SCAN_M1: pos_sel = scan_m1_pos_ext[SBI_POS_W-1:0];
            POS_SCAN:    pos_sel = scan_pos_ext[SBI_POS_W-1:0];
            default:     pos_sel = '0;
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_pos_reg    <= pos_sel;
            res_time_reg   <= cmd.res_use_rd ? rd_time : '0;
            res_value_reg  <= cmd.res_use_rd ? ram_rd_data[SBI_ENTRY_W-1:SBI_TIME_W] : '0;
        end
    end

    // Output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_pos_reg    <= res_pos_reg;
            m_count_reg  <= count_out_ext[SBI_COUNT_W-1:0];
            m_time_reg   <= res_time_reg;
            m_value_reg  <= res_value_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {3'b000, m_value_reg, m_time_reg, m_count_reg, m_pos_reg};

    // Status to controller
    always_comb begin
        stat.mode       = mode_reg;
        stat.negative   = time_reg[SBI_TIME_W-1];
        stat.idx_ok     = idx_ext < count_ext;
        stat.scan_zero  = (scan_reg == '0);
        stat.cmp_eq     = (rd_time == time_reg);
        stat.cmp_lt     = ($signed(rd_time) < time_reg);
        stat.full       = (count_reg == CW'(DEPTH));
        stat.mv_at_slot = (mv_reg == scan_reg);
        stat.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule : sbi_dpath
`default_nettype wire

// ----- hdl/sorted_breakpoint_insert.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_breakpoint_insert
// Table of up to DEPTH (time, value) breakpoints kept in ascending time order.
// ----------------------------------------------------------------------------
// One item at a time, one result per item. The table sits in a single-write,
// single-read RAM with registered read data. A search walks down from the top
// entry while stored times are larger; an equal time replaces the value, and
// an insert moves each entry above the new slot up by one, then writes the
// new pair. Reads past the valid entries, negative times and a full table
// give a result without touching the table. The next item is accepted as
// soon as the result is handed to the output register, even if that result
// is still waiting for m_tready; a result that finds the output register
// still held by an earlier item waits there for m_tready. No clearing pass
// after reset: only written entries are ever read.
module sorted_breakpoint_insert
    import sbi_pkg::*;
#(
    parameter int DEPTH = SBI_DEPTH_DEFAULT
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Input items
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // [31:0] point_time, [63:32] point_value, [69:64] read_index, [71:70] zero
    input  wire logic [SBI_S_DATA_W-1:0] s_tdata,
    // [0] mode
    input  wire logic                    s_tuser,
    // Result items
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [5:0] position, [12:6] entry_count, [44:13] entry_time,
    // [76:45] entry_value, [79:77] zero
    output logic      [SBI_M_DATA_W-1:0] m_tdata,
    // [2:0] status
    output logic      [2:0]              m_tuser
);

    sbi_cmd_t  cmd;
    sbi_stat_t stat;

    sbi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sbi_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule : sorted_breakpoint_insert
`default_nettype wire

// ----- hdl/sbi_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbi_checker
// Port-level checks for the breakpoint table, bound to the top level.
// ----------------------------------------------------------------------------
module sbi_checker
    import sbi_pkg::*;
(
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    m_tvalid,
    input wire logic                    m_tready,
    input wire logic [SBI_M_DATA_W-1:0] m_tdata,
    input wire logic [2:0]              m_tuser
);

    // A stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // Only defined status codes appear
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= ST_READ)
        else $error("undefined status code");

    // Only reads carry entry data
    a_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_READ |-> m_tdata[76:13] == '0)
        else $error("entry data on a non-read result");

    // Rejected inserts report position zero
    a_reject_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_NEGATIVE || m_tuser == ST_FULL)
        |-> m_tdata[5:0] == '0)
        else $error("rejected insert with non-zero position");

    // No result item straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule : sbi_checker

bind sorted_breakpoint_insert sbi_checker u_sbi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ----- tb/sorted_breakpoint_insert_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_breakpoint_insert_tb
// Self-checking bench for the sorted breakpoint table.
// ----------------------------------------------------------------------------
// A queue of items, filled by the stimulus process, feeds a clocked driver.
// Every accepted item is run through a local copy of the table, and the
// result it should give is queued. A clocked monitor compares each result
// item, field by field, against the oldest queued result. The table is
// filled slowly, so that inserts with long shifts, replaces, rejected
// negative times and a full table all occur. The run passes through four
// sender and receiver idling patterns.
module sorted_breakpoint_insert_tb;
    import sbi_pkg::*;

    localparam int TABLE_DEPTH  = SBI_DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int PHASE_ITEMS  = 160;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        logic        mode;
        logic [31:0] ptime;
        logic [31:0] pvalue;
        logic [5:0]  idx;
    } bp_item_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  position;
        logic [6:0]  count;
        logic [31:0] etime;
        logic [31:0] evalue;
    } bp_result_t;

    // Clock, reset and stream ports
    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [SBI_S_DATA_W-1:0] s_tdata  = '0;
    logic                    s_tuser  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [SBI_M_DATA_W-1:0] m_tdata;
    logic [2:0]              m_tuser;

    // Local copy of the table
    logic [31:0] bp_time  [TABLE_DEPTH];
    logic [31:0] bp_value [TABLE_DEPTH];
    int          table_count = 0;

    bp_item_t    pending_items[$];
    bp_result_t  expected_results[$];
    logic [31:0] known_times[$];     // times the table will hold, for stimulus

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic s_fire         = 1'b0;
    int   cycle_count    = 0;
    int   mismatches     = 0;
    int   results_seen   = 0;
    int   status_seen[5] = '{default: 0};
    int   peak_count     = 0;

    sorted_breakpoint_insert #(
        .DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Apply one item to the local table and return the result it gives
    function automatic bp_result_t apply_breakpoint(input bp_item_t it);
        bp_result_t r;
        int         n;
        int         slot;
        int         i;
        bit         found;
        r     = '0;
        n     = table_count;
        found = 1'b0;
        if (it.mode == MODE_READ) begin
            r.status   = ST_READ;
            r.position = it.idx;
            if (int'(it.idx) < n) begin
                r.etime  = bp_time[it.idx];
                r.evalue = bp_value[it.idx];
            end
        end else if (it.ptime[31]) begin
            r.status = ST_NEGATIVE;
        end else begin
            // an equal time replaces the value, even with a full table
            for (i = 0; i < n; i++) begin
                if (!found && bp_time[i] == it.ptime) begin
                    bp_value[i] = it.pvalue;
                    r.status    = ST_REPLACED;
                    r.position  = 6'(i);
                    found       = 1'b1;
                end
            end
            if (!found && n >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else if (!found) begin
                slot = n;
                while (slot > 0 && $signed(it.ptime) < $signed(bp_time[slot-1]))
                    slot--;
                for (i = n; i > slot; i--) begin
                    bp_time[i]  = bp_time[i-1];
                    bp_value[i] = bp_value[i-1];
                end
                bp_time[slot]  = it.ptime;
                bp_value[slot] = it.pvalue;
                table_count    = n + 1;
                r.status       = ST_INSERTED;
                r.position     = 6'(slot);
            end
        end
        r.count = 7'(table_count);
        return r;
    endfunction

    // Queue one item, tracking which times the table will come to hold
    task automatic queue_item(input logic mode, input logic [31:0] t,
                              input logic [31:0] v, input logic [5:0] idx);
        bp_item_t it;
        bit       seen;
        it      = '{mode: mode, ptime: t, pvalue: v, idx: idx};
        seen    = 1'b0;
        foreach (known_times[k])
            if (known_times[k] == t) seen = 1'b1;
        if (mode == MODE_INSERT && !t[31] && !seen && known_times.size() < TABLE_DEPTH)
            known_times.push_back(t);
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        do begin
            @(posedge aclk);
            #1;
        end while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Driver: a new item is offered only once the last one has gone
    always @(negedge aclk) begin : drive_items
        bp_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt      = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, nxt.idx, nxt.pvalue, nxt.ptime};
                s_tuser  <= nxt.mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Accepted items go through the local table
    always @(posedge aclk) begin : take_items
        bp_item_t it;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            it.mode   = s_tuser;
            it.ptime  = s_tdata[31:0];
            it.pvalue = s_tdata[63:32];
            it.idx    = s_tdata[69:64];
            expected_results.push_back(apply_breakpoint(it));
        end
    end

    // Monitor: compare each result item with the oldest expectation
    always @(posedge aclk) begin : check_results
        bp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result status %0d data %0h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                status_seen[want.status]++;
                if (int'(want.count) > peak_count) peak_count = int'(want.count);
                check_field("status",      32'(want.status),   32'(m_tuser));
                check_field("position",    32'(want.position), 32'(m_tdata[5:0]));
                check_field("entry_count", 32'(want.count),    32'(m_tdata[12:6]));
                check_field("entry_time",  want.etime,         m_tdata[44:13]);
                check_field("entry_value", want.evalue,        m_tdata[76:45]);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("sorted_breakpoint_insert: mismatch");
            $finish;
        end
    end

    // Stimulus
    initial begin : stimulus
        int          send_pct[4];
        int          recv_pct[4];
        int          r;
        logic [31:0] t;
        logic [31:0] v;
        logic [5:0]  idx;
        int          lim;
        send_pct = '{0, 84, 0, 27};
        recv_pct = '{0, 0, 84, 27};

        repeat (4) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        // Directed: empty reads, edge times and values, replace and shifts
        queue_item(MODE_READ,   $urandom, $urandom, 6'd0);
        queue_item(MODE_READ,   $urandom, $urandom, 6'd63);
        queue_item(MODE_INSERT, 32'h0000_0000, 32'h7FFF_FFFF, 6'd0);
        queue_item(MODE_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 6'd63);
        queue_item(MODE_INSERT, 32'h8000_0000, 32'h0000_0001, 6'd0);
        queue_item(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        queue_item(MODE_INSERT, 32'h0001_0000, 32'hFFFF_FFFF, 6'd0);
        queue_item(MODE_INSERT, 32'h0001_0000, 32'h0000_0000, 6'd0);
        queue_item(MODE_INSERT, 32'h0000_8000, 32'h0000_4000, 6'd0);
        queue_item(MODE_INSERT, 32'h0000_0000, 32'h1234_5678, 6'd0);
        queue_item(MODE_INSERT, 32'h7FFF_FFFE, 32'hDEAD_BEEF, 6'd0);
        queue_item(MODE_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd0);
        queue_item(MODE_READ,   32'h0, 32'h0, 6'd0);
        queue_item(MODE_READ,   32'h0, 32'h0, 6'd1);
        queue_item(MODE_READ,   32'h0, 32'h0, 6'd4);
        queue_item(MODE_READ,   32'h0, 32'h0, 6'd5);
        queue_item(MODE_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        queue_item(MODE_INSERT, 32'h0000_0001, 32'h8000_0000, 6'd63);
        queue_item(MODE_READ,   32'h0, 32'h0, 6'd1);
        wait_drained();

        // Random phases; the table fills slowly so every phase sees shifts
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r   = $urandom_range(0, 99);
                idx = 6'($urandom);
                v   = ($urandom_range(0, 9) == 0) ?
                      ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF) : $urandom;
                if (r < 13) begin
                    // new time: wide, clustered low, near a known time, or near the top
                    case ($urandom_range(0, 3))
                        0: t = $urandom & 32'h7FFF_FFFF;
                        1: t = $urandom_range(0, 255);
                        2: t = (known_times[$urandom_range(0, known_times.size() - 1)]
                                + $urandom_range(0, 2) - 1) & 32'h7FFF_FFFF;
                        default: t = 32'h7FFF_FFFF - $urandom_range(0, 255);
                    endcase
                    queue_item(MODE_INSERT, t, v, idx);
                end else if (r < 23) begin
                    queue_item(MODE_INSERT, $urandom | 32'h8000_0000, v, idx);
                end else if (r < 55) begin
                    t = known_times[$urandom_range(0, known_times.size() - 1)];
                    queue_item(MODE_INSERT, t, v, idx);
                end else begin
                    // mostly within or just past the valid entries
                    lim = (known_times.size() > 63) ? 63 : known_times.size();
                    if ($urandom_range(0, 9) < 7)
                        idx = 6'($urandom_range(0, lim));
                    queue_item(MODE_READ, $urandom, $urandom, idx);
                end
            end
            // sender holds off here until every result is back
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d results: %0d inserts, %0d replaces, %0d negative,",
                 results_seen, status_seen[ST_INSERTED], status_seen[ST_REPLACED],
                 status_seen[ST_NEGATIVE]);
        $display("  %0d full, %0d reads; table peaked at %0d of %0d entries",
                 status_seen[ST_FULL], status_seen[ST_READ], peak_count, TABLE_DEPTH);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("sorted_breakpoint_insert: match");
        end else begin
            $display("sorted_breakpoint_insert: mismatch");
        end
        $finish;
    end

endmodule
